### rtl/cae_pkg.sv
// ----------------------------------------------------------------------------
// cae_pkg
// shared widths, types and register codes of the cylinder axis estimator
// ----------------------------------------------------------------------------
package cae_pkg;

  localparam int NUM_PARAMS  = 6;
  localparam int NUM_SQUARE  = 3;
  localparam int COORD_W     = 16;
  localparam int OFS_W       = COORD_W + 1;
  localparam int PROD_W      = 2 * OFS_W;
  localparam int DIFF_W      = PROD_W + 1;
  localparam int FRAC_SHIFT  = 10;
  localparam int PHI_W       = DIFF_W - FRAC_SHIFT;
  localparam int THETA_W     = 32;
  localparam int ERR_W       = 32;
  localparam int GAIN_W      = 16;
  localparam int DOT_W       = THETA_W + PHI_W;
  localparam int SUM3_W      = DOT_W + 2;
  localparam int Z_W         = DOT_W + 3;
  localparam int PE_W        = PHI_W + ERR_W;
  localparam int T_W         = PE_W - FRAC_SHIFT;
  localparam int TH_W        = T_W - GAIN_W;
  localparam int PH_W        = TH_W + GAIN_W + 1;
  localparam int NV_W        = PH_W + 2;

  localparam int DEF_QUEUE_DEPTH = 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_GAIN     = 2'd0;
  localparam logic [1:0] REG_ORIGIN_X = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd328;

  typedef logic signed [PHI_W-1:0]   phi_t;
  typedef phi_t                      phi_vec_t [NUM_PARAMS];
  typedef logic signed [THETA_W-1:0] theta_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
  } cfg_t;

endpackage

### rtl/cae_ifs.sv
// ----------------------------------------------------------------------------
// cae channel interfaces
// point pair input channel and parameter estimate output channel
// ----------------------------------------------------------------------------
interface cae_point_if;
  import cae_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_y;
  logic signed [COORD_W-1:0] second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface cae_est_if;
  import cae_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [THETA_W-1:0] est_xx;
  logic signed [THETA_W-1:0] est_yy;
  logic signed [THETA_W-1:0] est_zz;
  logic signed [THETA_W-1:0] est_xy;
  logic signed [THETA_W-1:0] est_yz;
  logic signed [THETA_W-1:0] est_xz;

  modport source (
    output valid, est_xx, est_yy, est_zz, est_xy, est_yz, est_xz,
    input  ready
  );
  modport sink (
    input  valid, est_xx, est_yy, est_zz, est_xy, est_yz, est_xz,
    output ready
  );
endinterface

### rtl/cae_front.sv
// ----------------------------------------------------------------------------
// cae_front
// origin offsets, coordinate products and regressor for each point pair
// ----------------------------------------------------------------------------
module cae_front (
  input  logic              clk,
  input  logic              rst,
  cae_point_if.sink         points,
  input  cae_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output cae_pkg::phi_vec_t q_data
);
  import cae_pkg::*;

  logic                     v1;
  logic                     v2;
  logic                     move1;
  logic                     move2;
  logic signed [OFS_W-1:0]  ofs [2*NUM_SQUARE];
  logic signed [PROD_W-1:0] sq0 [NUM_SQUARE];
  logic signed [PROD_W-1:0] sq1 [NUM_SQUARE];
  logic signed [PROD_W-1:0] cr0 [NUM_SQUARE];
  logic signed [PROD_W-1:0] cr1 [NUM_SQUARE];
  logic signed [DIFF_W-1:0] diff [NUM_PARAMS];

  assign move2        = !v2 || !q_full;
  assign move1        = !v1 || move2;
  assign points.ready = move1;
  assign q_push       = v2 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (move1) v1 <= points.valid;
      if (move2) v2 <= v1;
    end
  end

  // offsets from the origin
  always_ff @(posedge clk) begin
    if (move1 && points.valid) begin
      ofs[0] <= OFS_W'($signed(points.first_x))  - OFS_W'($signed(cfg.origin_x));
      ofs[1] <= OFS_W'($signed(points.first_y))  - OFS_W'($signed(cfg.origin_y));
      ofs[2] <= OFS_W'($signed(points.first_z))  - OFS_W'($signed(cfg.origin_z));
      ofs[3] <= OFS_W'($signed(points.second_x)) - OFS_W'($signed(cfg.origin_x));
      ofs[4] <= OFS_W'($signed(points.second_y)) - OFS_W'($signed(cfg.origin_y));
      ofs[5] <= OFS_W'($signed(points.second_z)) - OFS_W'($signed(cfg.origin_z));
    end
  end

  // squared and cross products
  always_ff @(posedge clk) begin
    if (move2 && v1) begin
      for (int k = 0; k < NUM_SQUARE; k++) begin
        sq0[k] <= ofs[k] * ofs[k];
        sq1[k] <= ofs[k+NUM_SQUARE] * ofs[k+NUM_SQUARE];
      end
      cr0[0] <= ofs[0] * ofs[1];
      cr0[1] <= ofs[1] * ofs[2];
      cr0[2] <= ofs[0] * ofs[2];
      cr1[0] <= ofs[3] * ofs[4];
      cr1[1] <= ofs[4] * ofs[5];
      cr1[2] <= ofs[3] * ofs[5];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SQUARE; k++) begin
      diff[k]            = DIFF_W'(sq0[k]) - DIFF_W'(sq1[k]);
      diff[k+NUM_SQUARE] = DIFF_W'(cr0[k]) - DIFF_W'(cr1[k]);
    end
    for (int i = 0; i < NUM_PARAMS; i++) begin
      q_data[i] = diff[i][DIFF_W-1:FRAC_SHIFT];
    end
  end

endmodule

### rtl/cae_queue.sv
// ----------------------------------------------------------------------------
// cae_queue
// short regressor queue between front and back
// ----------------------------------------------------------------------------
module cae_queue #(
  parameter int DEPTH = cae_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cae_pkg::phi_vec_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output cae_pkg::phi_vec_t head
);
  import cae_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  phi_t             store [DEPTH][NUM_PARAMS];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    for (int i = 0; i < NUM_PARAMS; i++) head[i] = store[rd_ptr][i];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < NUM_PARAMS; i++) store[wr_ptr][i] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/cae_back.sv
// ----------------------------------------------------------------------------
// cae_back
// parameter update sequencer: prediction error, gain scaling, projection
// ----------------------------------------------------------------------------
module cae_back (
  input  logic              clk,
  input  logic              rst,
  input  cae_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  cae_pkg::phi_vec_t q_head,
  output logic              q_pop,
  cae_est_if.source         estimate
);
  import cae_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_ERR   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_GAIN  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  localparam theta_t THETA_ONE = 32'sh0100_0000;
  localparam logic signed [Z_W:0] SAT_MAX = (Z_W+1)'(32'sh7fff_ffff);
  localparam logic signed [Z_W:0] SAT_MIN = -SAT_MAX - 1;

  function automatic theta_t sat32(input logic signed [Z_W:0] v);
    if (v > SAT_MAX)      return SAT_MAX[THETA_W-1:0];
    else if (v < SAT_MIN) return SAT_MIN[THETA_W-1:0];
    else                  return v[THETA_W-1:0];
  endfunction

  logic [2:0]                state;
  logic [2:0]                state_next;
  theta_t                    theta [NUM_PARAMS];
  phi_t                      phi_r [NUM_PARAMS];
  logic signed [DOT_W-1:0]   prod  [NUM_PARAMS];
  logic signed [SUM3_W-1:0]  s0;
  logic signed [SUM3_W-1:0]  s1;
  logic signed [ERR_W-1:0]   err;
  logic signed [T_W-1:0]     t     [NUM_PARAMS];
  logic signed [PH_W-1:0]    ph    [NUM_PARAMS];
  logic [GAIN_W-1:0]         pl    [NUM_PARAMS];

  logic signed [Z_W-1:0]     z_sum;
  logic signed [Z_W:0]       neg_z;
  theta_t                    err_next;
  logic signed [PE_W-1:0]    pe    [NUM_PARAMS];
  logic [2*GAIN_W-1:0]       lo_mul [NUM_PARAMS];
  logic signed [NV_W-1:0]    d     [NUM_PARAMS];
  logic signed [NV_W-1:0]    nv    [NUM_PARAMS];
  theta_t                    theta_next [NUM_PARAMS];
  logic                      out_free;
  logic                      upd_fire;

  assign out_free = !estimate.valid || estimate.ready;
  assign upd_fire = (state == S_UPD) && out_free;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    z_sum    = Z_W'(s0) + Z_W'(s1);
    neg_z    = -((Z_W+1)'(z_sum));
    err_next = sat32(neg_z >>> FRAC_SHIFT);
    for (int i = 0; i < NUM_PARAMS; i++) begin
      pe[i]     = phi_r[i] * err;
      lo_mul[i] = {{GAIN_W{1'b0}}, t[i][GAIN_W-1:0]} * {{GAIN_W{1'b0}}, cfg.gain};
      d[i]      = NV_W'(ph[i]) + NV_W'($signed({1'b0, pl[i]}));
      // square terms may not be pushed further below zero
      if (i < NUM_SQUARE && theta[i][THETA_W-1] && d[i][NV_W-1]) d[i] = '0;
      nv[i]         = NV_W'(theta[i]) + d[i];
      theta_next[i] = sat32((Z_W+1)'(nv[i]));
      if (i < NUM_SQUARE && theta_next[i][THETA_W-1]) theta_next[i] = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty) state_next = S_SUM;
      S_SUM:   state_next = S_ERR;
      S_ERR:   state_next = S_SCALE;
      S_SCALE: state_next = S_GAIN;
      S_GAIN:  state_next = S_UPD;
      S_UPD:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      estimate.valid <= 1'b0;
      for (int i = 0; i < NUM_PARAMS; i++) begin
        theta[i] <= (i == 0 || i == 2) ? THETA_ONE : '0;
      end
    end else begin
      state <= state_next;
      if (upd_fire) begin
        estimate.valid <= 1'b1;
        for (int i = 0; i < NUM_PARAMS; i++) theta[i] <= theta_next[i];
      end else if (estimate.ready) begin
        estimate.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        phi_r[i] <= q_head[i];
        prod[i]  <= theta[i] * q_head[i];
      end
    end
    if (state == S_SUM) begin
      s0 <= SUM3_W'(prod[0]) + SUM3_W'(prod[1]) + SUM3_W'(prod[2]);
      s1 <= SUM3_W'(prod[3]) + SUM3_W'(prod[4]) + SUM3_W'(prod[5]);
    end
    if (state == S_ERR) err <= err_next;
    if (state == S_SCALE) begin
      for (int i = 0; i < NUM_PARAMS; i++) t[i] <= pe[i][PE_W-1:FRAC_SHIFT];
    end
    if (state == S_GAIN) begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        ph[i] <= $signed(t[i][T_W-1:GAIN_W]) * $signed({1'b0, cfg.gain});
        pl[i] <= lo_mul[i][2*GAIN_W-1:GAIN_W];
      end
    end
    if (upd_fire) begin
      estimate.est_xx <= theta_next[0];
      estimate.est_yy <= theta_next[1];
      estimate.est_zz <= theta_next[2];
      estimate.est_xy <= theta_next[3];
      estimate.est_yz <= theta_next[4];
      estimate.est_xz <= theta_next[5];
    end
  end

endmodule

### rtl/cylinder_axis_adaptive_estimator.sv
// ----------------------------------------------------------------------------
// cylinder_axis_adaptive_estimator
// gradient estimator of six quadric parameters from pairs of surface points
// ----------------------------------------------------------------------------
// points: valid/ready channel, one pair of Q5.10 points per transaction
// estimate: valid/ready channel, the six updated Q8.24 parameters per
//   transaction, one result for every point pair
// apb port: gain at 0x0, origin x/y/z at 0x4, 0x8, 0xc; write while idle
// latency: 8 cycles from an accepted pair to a valid estimate with no stall
// throughput: one pair every 6 cycles, set by the parameter update loop in
//   the back sequencer (dot product, error, scale, gain, update)
// the front builds regressors for following pairs meanwhile and parks them
//   in a two-entry queue, so pairs are still taken while a result waits
// a stalled estimate holds its payload; the next update waits for the slot,
//   then the queue fills and points.ready falls
// reset: gain 328, origins 0, parameters 1.0 0 1.0 0 0 0, queue empty
// ----------------------------------------------------------------------------
module cylinder_axis_adaptive_estimator #(
  parameter int QUEUE_DEPTH = cae_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cae_pkg::ADDR_W-1:0] paddr,
  input  logic [cae_pkg::DATA_W-1:0] pwdata,
  output logic [cae_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  cae_point_if.sink                  points,
  cae_est_if.source                  estimate
);
  import cae_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  phi_vec_t   q_data;
  phi_vec_t   q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain     <= GAIN_RESET;
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.origin_z <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN:     cfg.gain     <= pwdata[GAIN_W-1:0];
        REG_ORIGIN_X: cfg.origin_x <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y: cfg.origin_y <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Z: cfg.origin_z <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:     prdata = DATA_W'(cfg.gain);
      REG_ORIGIN_X: prdata = DATA_W'(cfg.origin_x);
      REG_ORIGIN_Y: prdata = DATA_W'(cfg.origin_y);
      REG_ORIGIN_Z: prdata = DATA_W'(cfg.origin_z);
      default:      prdata = '0;
    endcase
  end

  cae_front u_front (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  cae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  cae_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .estimate (estimate)
  );

  a_square_nonneg: assert property (@(posedge clk) disable iff (rst)
    estimate.valid |-> (!estimate.est_xx[THETA_W-1] && !estimate.est_yy[THETA_W-1]
                        && !estimate.est_zz[THETA_W-1]))
    else $error("square term parameter negative");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("regressor queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("regressor queue pushed while full");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !estimate.valid)
    else $error("estimate valid after reset");

endmodule
